>>> rtl/core/hfs_pkg.sv
`timescale 1ns / 1ps
package hfs_pkg;

    localparam int TAPS       = 31;
    localparam int CENTER     = TAPS / 2;
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int TRIG_W     = 16;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int ACC_W      = PROD_W + $clog2(TAPS);
    localparam int PHASE_W    = 32;
    localparam int SINE_DEPTH = 1024;
    localparam int SINE_AW    = $clog2(SINE_DEPTH);
    localparam int GAIN_W     = 16;
    localparam int FRAC_W     = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [PHASE_W-1:0] PHASE_INC_RESET = PHASE_W'(32'd8947849);
    localparam logic [GAIN_W-1:0]  MIX_GAIN_RESET  = GAIN_W'(16'd22938);

    // Q2.30 constants for the table generators
    localparam logic [63:0] PI_Q30      = 64'd3373259426;
    localparam logic [63:0] TWO_PI_Q30  = 64'd2 * PI_Q30;
    localparam logic [63:0] HALF_PI_Q30 = PI_Q30 / 64'd2;
    localparam logic [63:0] WIN_A_Q30   = 64'd579820585;
    localparam logic [63:0] WIN_B_Q30   = 64'd493921239;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_INC = 2'd0,
        CFG_MIX_GAIN  = 2'd1
    } t_cfg_index;

    typedef struct packed {
        logic advance;  // every stage moves one place
        logic load;     // a new sample enters with this move
    } t_pipe_ctrl;

    // Restoring long division, truncating; builds the tap constants
    function automatic logic [63:0] long_div(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], num[i]};
            if (r >= {1'b0, den}) begin
                r    = r - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Taylor series to the x^13 term, x in [0, pi/2], Q2.30, truncating steps
    function automatic logic [63:0] sin_mag_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        x2 = (x * x) >> 30;
        s  = x;
        t  = ((x * x2) >> 30) / 64'd6;
        s  = s - t;
        t  = ((t * x2) >> 30) / 64'd20;
        s  = s + t;
        t  = ((t * x2) >> 30) / 64'd42;
        s  = s - t;
        t  = ((t * x2) >> 30) / 64'd72;
        s  = s + t;
        t  = ((t * x2) >> 30) / 64'd110;
        s  = s - t;
        t  = ((t * x2) >> 30) / 64'd156;
        s  = s + t;
        return s;
    endfunction

    function automatic logic signed [63:0] sin_q30(input logic [63:0] angle);
        logic [63:0] a;
        logic        neg;
        logic [63:0] m;
        a   = angle % TWO_PI_Q30;
        neg = 1'b0;
        if (a >= PI_Q30) begin
            neg = 1'b1;
            a   = a - PI_Q30;
        end
        if (a > HALF_PI_Q30) begin
            a = PI_Q30 - a;
        end
        m = sin_mag_q30(a);
        return neg ? -$signed(m) : $signed(m);
    endfunction

    // Q1.15 sine table entry j, rounded half up
    function automatic logic signed [TRIG_W-1:0] sine_entry(input int j);
        logic [63:0]        angle;
        logic signed [63:0] s;
        logic [63:0]        mag;
        logic [63:0]        q;
        angle = (TWO_PI_Q30 * 64'(j)) / SINE_DEPTH;
        s     = sin_q30(angle);
        mag   = (s < 0) ? 64'(-s) : 64'(s);
        q     = (mag * 64'd32767 + (64'd1 << 29)) >> 30;
        if (q > 64'd32767) begin
            q = 64'd32767;
        end
        return (s < 0) ? -$signed(TRIG_W'(q)) : $signed(TRIG_W'(q));
    endfunction

    // Hamming-windowed Hilbert tap, Q1.15, zero at the center
    function automatic logic signed [COEF_W-1:0] hilbert_coef(input int k);
        int                 n;
        logic [63:0]        angle;
        logic signed [63:0] c;
        logic [63:0]        w;
        logic [63:0]        an;
        logic [63:0]        num;
        logic [63:0]        den;
        logic [63:0]        h;
        n = k - CENTER;
        if (n == 0) begin
            return '0;
        end
        angle = (TWO_PI_Q30 * 64'(k)) / (TAPS - 1);
        c     = sin_q30(angle + HALF_PI_Q30);
        if (c >= 0) begin
            w = WIN_A_Q30 - ((WIN_B_Q30 * 64'(c)) >> 30);
        end else begin
            w = WIN_A_Q30 + ((WIN_B_Q30 * 64'(-c)) >> 30);
        end
        an  = (n < 0) ? 64'(-n) : 64'(n);
        num = 64'd2 * w * 64'd32768;
        den = PI_Q30 * an;
        h   = long_div(num + (den >> 1), den);
        return (n < 0) ? -$signed(COEF_W'(h)) : $signed(COEF_W'(h));
    endfunction

endpackage

>>> rtl/core/hfs_cell.sv
`timescale 1ns / 1ps
module hfs_cell
    import hfs_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_shift,
    input  logic signed [COEF_W-1:0]   i_coef,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic signed [ACC_W-1:0]    i_psum,
    output logic signed [ACC_W-1:0]    o_psum
);

    logic signed [PROD_W-1:0] w_prod;
    logic signed [ACC_W-1:0]  n_psum;
    logic signed [ACC_W-1:0]  r_psum;

    assign w_prod = i_sample * i_coef;
    assign n_psum = ACC_W'(w_prod) + i_psum;

    // hold the partial sum between samples
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_psum <= '0;
        end else if (i_shift) begin
            r_psum <= n_psum;
        end
    end

    assign o_psum = r_psum;

endmodule

>>> rtl/core/hfs_fir.sv
`timescale 1ns / 1ps
module hfs_fir
    import hfs_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_shift,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    output logic signed [ACC_W-1:0]    o_sum
);

    // w_psum[k] is the register of cell k; the far end feeds zero
    logic signed [ACC_W-1:0] w_psum [TAPS+1];

    assign w_psum[TAPS] = '0;

    for (genvar k = 0; k < TAPS; k++) begin : g_tap
        localparam logic signed [COEF_W-1:0] TapCoef = hilbert_coef(k);

        hfs_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_shift  (i_shift),
            .i_coef   (TapCoef),
            .i_sample (i_sample),
            .i_psum   (w_psum[k+1]),
            .o_psum   (w_psum[k])
        );
    end

    assign o_sum = w_psum[0];

endmodule

>>> rtl/core/hfs_sine_rom.sv
`timescale 1ns / 1ps
module hfs_sine_rom
    import hfs_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [SINE_AW-1:0]       i_addr,
    output logic signed [TRIG_W-1:0] o_sin,
    output logic signed [TRIG_W-1:0] o_cos
);

    logic signed [TRIG_W-1:0] w_table [SINE_DEPTH];
    logic [SINE_AW-1:0]       w_cos_addr;
    logic signed [TRIG_W-1:0] r_sin;
    logic signed [TRIG_W-1:0] r_cos;

    for (genvar j = 0; j < SINE_DEPTH; j++) begin : g_entry
        localparam logic signed [TRIG_W-1:0] EntryValue = sine_entry(j);
        assign w_table[j] = EntryValue;
    end

    // cosine is the sine a quarter turn ahead, wrapping at the table end
    assign w_cos_addr = i_addr + SINE_AW'(SINE_DEPTH / 4);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin <= w_table[i_addr];
            r_cos <= w_table[w_cos_addr];
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

>>> rtl/core/hfs_mixer.sv
`timescale 1ns / 1ps
module hfs_mixer
    import hfs_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_pipe_ctrl                 i_ctrl,
    input  logic signed [SAMPLE_W-1:0] i_dry,
    input  logic signed [ACC_W-1:0]    i_fir_sum,
    input  logic signed [TRIG_W-1:0]   i_sin,
    input  logic signed [TRIG_W-1:0]   i_cos,
    input  logic [GAIN_W-1:0]          i_gain,
    output logic                       o_valid,
    output logic signed [SAMPLE_W-1:0] o_audio
);

    localparam int IMAG_W  = ACC_W - FRAC_W;
    localparam int DC_W    = SAMPLE_W + TRIG_W;
    localparam int IS_W    = IMAG_W + TRIG_W;
    localparam int DIFF_W  = ((DC_W > IS_W) ? DC_W : IS_W) + 1;
    localparam int SHIFT_W = DIFF_W - FRAC_W;
    localparam int G_W     = FRAC_W + 2;
    localparam int WET_W   = G_W + SHIFT_W;
    localparam int DRYP_W  = G_W + SAMPLE_W;
    localparam int MIX_W   = ((WET_W > DRYP_W) ? WET_W : DRYP_W) + 1;
    localparam int Y_W     = MIX_W - FRAC_W;

    localparam logic signed [G_W-1:0] Unity   = G_W'(2 ** FRAC_W);
    localparam logic signed [Y_W-1:0] OutMax  = Y_W'(2 ** (SAMPLE_W - 1) - 1);
    localparam logic signed [Y_W-1:0] OutMin  = -Y_W'(2 ** (SAMPLE_W - 1));

    logic r1_valid;
    logic r2_valid;
    logic r3_valid;
    logic r4_valid;
    logic r_out_valid;

    logic signed [SAMPLE_W-1:0] r1_dry;
    logic signed [SAMPLE_W-1:0] r2_dry;
    logic signed [SAMPLE_W-1:0] r3_dry;
    logic signed [DC_W-1:0]     r2_dc;
    logic signed [IS_W-1:0]     r2_is;
    logic signed [SHIFT_W-1:0]  r3_shift;
    logic signed [WET_W-1:0]    r4_wet;
    logic signed [DRYP_W-1:0]   r4_dryp;
    logic signed [SAMPLE_W-1:0] r_out;

    logic signed [ACC_W-1:0]  w_acc_rnd;
    logic signed [IMAG_W-1:0] w_imag;
    logic signed [DIFF_W-1:0] w_diff_rnd;
    logic signed [G_W-1:0]    w_g;
    logic signed [G_W-1:0]    w_gd;
    logic signed [MIX_W-1:0]  w_mix_rnd;
    logic signed [Y_W-1:0]    w_y;
    logic signed [SAMPLE_W-1:0] w_sat;

    // round half up, then drop the fraction
    assign w_acc_rnd  = i_fir_sum + ACC_W'(2 ** (FRAC_W - 1));
    assign w_imag     = $signed(w_acc_rnd[ACC_W-1:FRAC_W]);
    assign w_diff_rnd = DIFF_W'(r2_dc) - DIFF_W'(r2_is) + DIFF_W'(2 ** (FRAC_W - 1));

    // gain above unity acts as unity
    assign w_g  = ({1'b0, i_gain} > (GAIN_W + 1)'(2 ** FRAC_W)) ? Unity : G_W'(i_gain);
    assign w_gd = Unity - w_g;

    assign w_mix_rnd = MIX_W'(r4_wet) + MIX_W'(r4_dryp) + MIX_W'(2 ** (FRAC_W - 1));
    assign w_y       = $signed(w_mix_rnd[MIX_W-1:FRAC_W]);

    always_comb begin
        if (w_y > OutMax) begin
            w_sat = OutMax[SAMPLE_W-1:0];
        end else if (w_y < OutMin) begin
            w_sat = OutMin[SAMPLE_W-1:0];
        end else begin
            w_sat = w_y[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r4_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_ctrl.advance) begin
            r1_valid    <= i_ctrl.load;
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid;
            r4_valid    <= r3_valid;
            r_out_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.advance) begin
            r1_dry   <= i_dry;
            r2_dry   <= r1_dry;
            r2_dc    <= r1_dry * i_cos;
            r2_is    <= w_imag * i_sin;
            r3_dry   <= r2_dry;
            r3_shift <= $signed(w_diff_rnd[DIFF_W-1:FRAC_W]);
            r4_wet   <= w_g * r3_shift;
            r4_dryp  <= w_gd * r3_dry;
            r_out    <= w_sat;
        end
    end

    assign o_valid = r_out_valid;
    assign o_audio = r_out;

endmodule

>>> rtl/core/hilbert_frequency_shifter.sv
`timescale 1ns / 1ps
// Hilbert single-sideband frequency shifter for a Q1.15 audio stream.
// Input channel: i_in_valid / o_in_stall carry one sample beat (i_audio_in).
// Output channel: o_out_valid / i_out_stall carry one result beat (o_audio_out).
// Config channel: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data;
//   index 0 is the phase step, index 1 the wet gain, other indexes are dropped.
//   Write config only while no samples are in flight.
// Throughput: one sample per cycle unless the output stalls. The 31 cells
//   of the transposed Hilbert chain each update their partial sum in the
//   cycle a sample is taken, and the sine table has two registered read ports,
//   so nothing iterates. A sample passes the tap chain and sine table, then
//   the mixer's product, shift, wet/dry and output registers.
// A stalled output beat holds the whole pipe: o_in_stall rises while the
//   output register holds a beat the receiver stalls, and every stage holds.
// Reset clears the tap chain, the phase accumulator and the pipe, and loads
//   the config registers with their defaults (shift step and 0.7 wet gain).
module hilbert_frequency_shifter
    import hfs_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [SAMPLE_W-1:0] i_audio_in,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [SAMPLE_W-1:0] o_audio_out,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data
);

    logic [PHASE_W-1:0] r_phase_inc;
    logic [GAIN_W-1:0]  r_mix_gain;
    logic [PHASE_W-1:0] r_phase;
    logic [PHASE_W-1:0] n_phase;

    logic                     w_advance;
    logic                     w_accept;
    t_pipe_ctrl               w_ctrl;
    logic signed [ACC_W-1:0]  w_fir_sum;
    logic signed [TRIG_W-1:0] w_sin;
    logic signed [TRIG_W-1:0] w_cos;

    // the pipe moves unless the output register holds a stalled beat
    assign w_advance   = !(o_out_valid && i_out_stall);
    assign w_accept    = i_in_valid && w_advance;
    assign o_in_stall  = !w_advance;
    assign o_cfg_ready = 1'b1;

    assign w_ctrl.advance = w_advance;
    assign w_ctrl.load    = i_in_valid;

    // config registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_inc <= PHASE_INC_RESET;
            r_mix_gain  <= MIX_GAIN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PHASE_INC: r_phase_inc <= i_cfg_data[PHASE_W-1:0];
                CFG_MIX_GAIN:  r_mix_gain  <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // use the phase for this sample, then advance it; wraps naturally
    assign n_phase = r_phase + r_phase_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (w_accept) begin
            r_phase <= n_phase;
        end
    end

    hfs_fir u_fir (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_shift  (w_accept),
        .i_sample (i_audio_in),
        .o_sum    (w_fir_sum)
    );

    // table index is the top bits of the phase
    hfs_sine_rom u_rom (
        .i_clk  (i_clk),
        .i_en   (w_advance),
        .i_addr (r_phase[PHASE_W-1 -: SINE_AW]),
        .o_sin  (w_sin),
        .o_cos  (w_cos)
    );

    hfs_mixer u_mixer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_ctrl),
        .i_dry     (i_audio_in),
        .i_fir_sum (w_fir_sum),
        .i_sin     (w_sin),
        .i_cos     (w_cos),
        .i_gain    (r_mix_gain),
        .o_valid   (o_out_valid),
        .o_audio   (o_audio_out)
    );

    a_phase_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_phase == $past(r_phase + r_phase_inc))
        else $error("phase did not advance by one step on an accepted beat");

    a_phase_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(r_phase))
        else $error("phase moved without an accepted beat");

    a_fir_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(w_fir_sum))
        else $error("tap chain moved without an accepted beat");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_audio_out))
        else $error("stalled result beat was not held");

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
module tb;
    import hfs_pkg::*;

    // Tap count, table depth and angle constants of the shifter, kept locally
    // for the predictor; the sample width still comes from hfs_pkg.
    localparam int N_TAPS    = 31;
    localparam int MID_TAP   = N_TAPS / 2;
    localparam int ROM_DEPTH = 1024;
    localparam int QUARTER   = ROM_DEPTH / 4;

    // Q2.30 angles and Hamming window weights
    localparam bit [63:0] ANG_PI      = 64'd3373259426;
    localparam bit [63:0] ANG_2PI     = 64'd2 * ANG_PI;
    localparam bit [63:0] ANG_HALF_PI = ANG_PI / 64'd2;
    localparam bit [63:0] HAMMING_A   = 64'd579820585;
    localparam bit [63:0] HAMMING_B   = 64'd493921239;

    localparam longint UNITY_GAIN = 32768;
    localparam longint HALF_LSB   = 16384;
    localparam longint SAT_MAX    = 32767;
    localparam longint SAT_MIN    = -32768;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    localparam logic [CFG_DATA_W-1:0] PHASE_ZERO = 32'h0000_0000;
    localparam logic [CFG_DATA_W-1:0] PHASE_HALF = 32'h8000_0000;
    localparam logic [CFG_DATA_W-1:0] PHASE_MAX  = 32'hFFFF_FFFF;
    localparam logic [CFG_DATA_W-1:0] GAIN_DRY   = 32'd0;
    localparam logic [CFG_DATA_W-1:0] GAIN_WET   = 32'd32768;
    localparam logic [CFG_DATA_W-1:0] GAIN_OVER  = 32'd65535;

    // Register indexes the block does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    localparam int HOLD_LEN      = 80;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_TAIL    = 20;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int SEG_COUNT     = 9;
    localparam int SEG_BEATS     = 120;

    typedef enum logic [2:0] {
        ITEM_SAMPLE,
        ITEM_CFG,
        ITEM_DRAIN,
        ITEM_MODE,
        ITEM_HOLD
    } t_stim_kind;

    // One entry of the stimulus list: a sample beat, a register write, or a
    // control step (idle mode change, receiver hold-off, drain pause).
    typedef struct {
        t_stim_kind                  kind;
        logic signed [SAMPLE_W-1:0]  sample;
        logic [CFG_IDX_W-1:0]        cfg_idx;
        logic [CFG_DATA_W-1:0]       cfg_data;
        int                          arg_a;
        int                          arg_b;
    } t_stim_item;

    // DUT ports; every input starts at a known value
    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_in_valid  = 1'b0;
    logic                       o_in_stall;
    logic signed [SAMPLE_W-1:0] i_audio_in  = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] o_audio_out;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data  = '0;

    // Stimulus list and the store of predicted output samples
    t_stim_item                 pend[$];
    logic signed [SAMPLE_W-1:0] expected_mix[$];

    // Predictor tables and state
    longint         sine_tab[ROM_DEPTH];
    longint         hilbert_tap[N_TAPS];
    longint         tap_hist[N_TAPS];
    int             hist_slot;
    logic [31:0]    phase_acc;
    logic [31:0]    step_inc;
    logic [15:0]    wet_gain;

    // Handshake bookkeeping shared between the processes
    int             in_flight;
    int             idle_run;
    int             tx_idle_pct;
    int             rx_idle_pct = 0;
    int             hold_req    = 0;
    int             hold_len    = 0;
    int             hold_ack;
    int             hold_left;
    int             mismatches  = 0;
    int             cycle_count = 0;

    hilbert_frequency_shifter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_audio_in  (i_audio_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_audio_out (o_audio_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Taylor series of sin up to x^13 on a Q2.30 angle in [0, pi/2];
    // every product and every division truncates.
    function automatic bit [63:0] taylor_mag(input bit [63:0] x);
        bit [63:0] x2;
        bit [63:0] term;
        bit [63:0] acc;
        x2   = (x * x) >> 30;
        term = x;
        acc  = x;
        for (int i = 1; i <= 6; i++) begin
            term = ((term * x2) >> 30) / 64'((2 * i) * (2 * i + 1));
            if (i % 2 == 1) begin
                acc = acc - term;
            end else begin
                acc = acc + term;
            end
        end
        return acc;
    endfunction

    // Signed Q2.30 sine of any nonnegative Q2.30 angle: fold into the first
    // quadrant, then restore the sign.
    function automatic longint angle_sine(input bit [63:0] angle);
        bit [63:0] a;
        bit        neg;
        longint    mag;
        a   = angle % ANG_2PI;
        neg = 1'b0;
        if (a >= ANG_PI) begin
            neg = 1'b1;
            a   = a - ANG_PI;
        end
        if (a > ANG_HALF_PI) begin
            a = ANG_PI - a;
        end
        mag = taylor_mag(a);
        return neg ? -mag : mag;
    endfunction

    // Advance the model by one sample and return the mixed output sample.
    // The dry path is the current sample, not delayed to the FIR center.
    function automatic logic signed [SAMPLE_W-1:0] shift_and_mix(
        input logic signed [SAMPLE_W-1:0] din
    );
        longint   dry;
        longint   acc;
        longint   imag;
        longint   cosv;
        longint   sinv;
        longint   shifted;
        longint   g;
        longint   y;
        int       pos;
        int       idx;
        dry = din;
        tap_hist[hist_slot] = dry;
        acc = 0;
        // tap k weighs the sample that entered k beats ago
        for (int k = 0; k < N_TAPS; k++) begin
            pos = (hist_slot + N_TAPS - k) % N_TAPS;
            acc = acc + tap_hist[pos] * hilbert_tap[k];
        end
        hist_slot = (hist_slot + 1) % N_TAPS;
        imag = (acc + HALF_LSB) >>> 15;

        // use the phase first, then advance it modulo 2^32
        idx       = int'(phase_acc[31:22]);
        sinv      = sine_tab[idx];
        cosv      = sine_tab[(idx + QUARTER) % ROM_DEPTH];
        phase_acc = phase_acc + step_inc;

        shifted = (dry * cosv - imag * sinv + HALF_LSB) >>> 15;

        // a gain above one acts as one
        g = (longint'(wet_gain) > UNITY_GAIN) ? UNITY_GAIN : longint'(wet_gain);
        y = ((UNITY_GAIN - g) * dry + g * shifted + HALF_LSB) >>> 15;
        if (y > SAT_MAX) begin
            y = SAT_MAX;
        end
        if (y < SAT_MIN) begin
            y = SAT_MIN;
        end
        return SAMPLE_W'(y);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus list helpers
    // ------------------------------------------------------------------

    function automatic void push_item(
        input t_stim_kind                 kind,
        input logic signed [SAMPLE_W-1:0] sample,
        input logic [CFG_IDX_W-1:0]       cfg_idx,
        input logic [CFG_DATA_W-1:0]      cfg_data,
        input int                         arg_a,
        input int                         arg_b
    );
        t_stim_item it;
        it.kind     = kind;
        it.sample   = sample;
        it.cfg_idx  = cfg_idx;
        it.cfg_data = cfg_data;
        it.arg_a    = arg_a;
        it.arg_b    = arg_b;
        pend.push_back(it);
    endfunction

    function automatic void add_sample(input logic signed [SAMPLE_W-1:0] v);
        push_item(ITEM_SAMPLE, v, '0, '0, 0, 0);
    endfunction

    function automatic void add_cfg(
        input logic [CFG_IDX_W-1:0]  idx,
        input logic [CFG_DATA_W-1:0] data
    );
        push_item(ITEM_CFG, '0, idx, data, 0, 0);
    endfunction

    // arg_a: sender idle percent, arg_b: receiver idle percent
    function automatic void add_mode(input int tx_pct, input int rx_pct);
        push_item(ITEM_MODE, '0, '0, '0, tx_pct, rx_pct);
    endfunction

    // Mostly full-range noise, with quiet stretches and full-scale hits
    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        int v;
        case ($urandom_range(9))
            0: begin
                return $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
            end
            1, 2: begin
                v = $urandom_range(512);
                return SAMPLE_W'(v - 256);
            end
            default: begin
                return SAMPLE_W'($urandom);
            end
        endcase
    endfunction

    // Positive and negative audio-rate shifts, any 32-bit step, and the corners
    function automatic logic [CFG_DATA_W-1:0] rand_step();
        case ($urandom_range(5))
            0: return 32'($urandom);
            1: return 32'($urandom_range(1 << 24));
            2: return 32'd0 - 32'($urandom_range(1 << 24));
            3: return PHASE_ZERO;
            4: return PHASE_HALF;
            default: return PHASE_MAX;
        endcase
    endfunction

    // Gains inside the range, above unity, and the corners
    function automatic logic [CFG_DATA_W-1:0] rand_gain();
        case ($urandom_range(4))
            0, 1: return 32'($urandom_range(32768));
            2: return 32'($urandom_range(65535));
            3: return $urandom_range(1) ? GAIN_DRY : GAIN_WET;
            default: return GAIN_OVER;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: feed sample and register beats from the stimulus list
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic       in_hold;
        logic       cfg_hold;
        logic       in_v;
        logic       cfg_v;
        t_stim_item nxt;
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_cfg_valid <= 1'b0;
            for (int k = 0; k < N_TAPS; k++) begin
                tap_hist[k] = 0;
            end
            hist_slot = 0;
            phase_acc = '0;
            step_inc  = PHASE_INC_RESET;
            wet_gain  = MIX_GAIN_RESET;
            in_flight = 0;
            idle_run  = 0;
        end else begin
            // a beat still waiting for acceptance stays on the wires as is
            in_hold  = i_in_valid && o_in_stall;
            cfg_hold = i_cfg_valid && !o_cfg_ready;

            // predict each accepted sample beat
            if (i_in_valid && !o_in_stall) begin
                expected_mix.push_back(shift_and_mix(i_audio_in));
                in_flight++;
            end
            if (o_out_valid && !i_out_stall) begin
                in_flight--;
            end
            // mirror accepted register writes; unknown indexes are dropped
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_PHASE_INC) begin
                    step_inc = i_cfg_data;
                end else if (i_cfg_index == CFG_MIX_GAIN) begin
                    wet_gain = i_cfg_data[15:0];
                end
            end
            idle_run = (in_flight <= 0) ? idle_run + 1 : 0;

            in_v  = in_hold;
            cfg_v = cfg_hold;
            if (!in_hold && !cfg_hold && pend.size() != 0) begin
                nxt = pend[0];
                case (nxt.kind)
                    ITEM_SAMPLE: begin
                        // idle at random, otherwise offer the next beat
                        if ($urandom_range(99) >= tx_idle_pct) begin
                            i_audio_in <= nxt.sample;
                            in_v = 1'b1;
                            pend.delete(0);
                        end
                    end
                    ITEM_CFG: begin
                        // write only once the pipe has emptied and settled
                        if (idle_run >= SETTLE_CYCLES) begin
                            i_cfg_index <= nxt.cfg_idx;
                            i_cfg_data  <= nxt.cfg_data;
                            cfg_v = 1'b1;
                            pend.delete(0);
                        end
                    end
                    ITEM_DRAIN: begin
                        // pause the sender until every result is back
                        if (in_flight <= 0) begin
                            pend.delete(0);
                        end
                    end
                    ITEM_MODE: begin
                        tx_idle_pct = nxt.arg_a;
                        rx_idle_pct <= nxt.arg_b;
                        pend.delete(0);
                    end
                    ITEM_HOLD: begin
                        hold_req <= hold_req + 1;
                        hold_len <= nxt.arg_a;
                        pend.delete(0);
                    end
                    default: begin
                        pend.delete(0);
                    end
                endcase
            end
            i_in_valid  <= in_v;
            i_cfg_valid <= cfg_v;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall, plus a long hold-off on request so the pipe
    // fills and pushes back on the input
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_ack  = 0;
            hold_left = 0;
        end else begin
            if (hold_req != hold_ack) begin
                hold_ack  = hold_req;
                hold_left = hold_len;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each accepted result beat against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic signed [SAMPLE_W-1:0] want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_mix.size() == 0) begin
                $display("%0t: audio_out beat with nothing pending, expected none, actual %0d",
                         $time, o_audio_out);
                mismatches++;
            end else begin
                want = expected_mix.pop_front();
                if (o_audio_out !== want) begin
                    $display("%0t: audio_out mismatch, expected %0d, actual %0d",
                             $time, want, o_audio_out);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** hilbert_frequency_shifter: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tables, stimulus list, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        longint    s;
        bit [63:0] mag;
        bit [63:0] q;
        longint    c;
        bit [63:0] cm;
        bit [63:0] w;
        bit [63:0] num;
        bit [63:0] den;
        bit [63:0] h;
        int        n;

        // sine table in Q1.15, rounded half up
        for (int j = 0; j < ROM_DEPTH; j++) begin
            s   = angle_sine((ANG_2PI * 64'(j)) / 64'(ROM_DEPTH));
            mag = (s < 0) ? -s : s;
            q   = (mag * 64'd32767 + (64'd1 << 29)) >> 30;
            if (q > 64'd32767) begin
                q = 64'd32767;
            end
            sine_tab[j] = (s < 0) ? -longint'(q) : longint'(q);
        end

        // Hamming-windowed Hilbert taps, zero at the center
        for (int k = 0; k < N_TAPS; k++) begin
            n = k - MID_TAP;
            if (n == 0) begin
                hilbert_tap[k] = 0;
            end else begin
                c = angle_sine((ANG_2PI * 64'(k)) / 64'(N_TAPS - 1) + ANG_HALF_PI);
                if (c >= 0) begin
                    cm = c;
                    w  = HAMMING_A - ((HAMMING_B * cm) >> 30);
                end else begin
                    cm = -c;
                    w  = HAMMING_A + ((HAMMING_B * cm) >> 30);
                end
                num = 64'd2 * w * 64'd32768;
                den = ANG_PI * 64'((n < 0) ? -n : n);
                h   = (num + den / 64'd2) / den;
                hilbert_tap[k] = (n < 0) ? -longint'(h) : longint'(h);
            end
        end

        tx_idle_pct = 0;
        add_mode(37, 69);

        // Directed: full-scale and corner samples under the reset settings
        add_sample(SAMPLE_MAX);
        add_sample(SAMPLE_MIN);
        add_sample(16'sd0);
        add_sample(16'sd1);
        add_sample(-16'sd1);
        add_sample(16'sh5555);
        add_sample(16'shAAAA);
        add_sample(SAMPLE_MAX);

        // fully wet with the largest step (a negative shift of one LSB)
        add_cfg(CFG_PHASE_INC, PHASE_MAX);
        add_cfg(CFG_MIX_GAIN, GAIN_WET);
        add_sample(SAMPLE_MAX);
        add_sample(SAMPLE_MAX);
        add_sample(SAMPLE_MIN);
        add_sample(SAMPLE_MIN);
        add_sample(SAMPLE_MAX);
        add_sample(SAMPLE_MIN);

        // gain above unity, half-turn step, writes to undecoded indexes
        add_cfg(CFG_PHASE_INC, PHASE_HALF);
        add_cfg(CFG_MIX_GAIN, GAIN_OVER);
        add_cfg(CFG_SPARE_2, PHASE_MAX);
        add_cfg(CFG_SPARE_3, PHASE_ZERO);
        add_sample(SAMPLE_MIN);
        add_sample(SAMPLE_MAX);
        add_sample(16'sd0);
        add_sample(-16'sd1);
        add_sample(SAMPLE_MAX);
        add_sample(SAMPLE_MIN);

        // dry only, phase frozen
        add_cfg(CFG_PHASE_INC, PHASE_ZERO);
        add_cfg(CFG_MIX_GAIN, GAIN_DRY);
        add_sample(SAMPLE_MAX);
        add_sample(SAMPLE_MIN);
        add_sample(16'sd12345);
        add_sample(-16'sd12345);

        // Random segments, a fresh setting per segment; the last third runs
        // without idling and adds a long receiver hold and a drain pause
        for (int seg = 0; seg < SEG_COUNT; seg++) begin
            if (seg == SEG_COUNT / 3) begin
                add_mode(69, 37);
            end
            if (seg == 2 * SEG_COUNT / 3) begin
                add_mode(0, 0);
            end
            add_cfg(CFG_PHASE_INC, rand_step());
            add_cfg(CFG_MIX_GAIN, rand_gain());
            for (int i = 0; i < SEG_BEATS; i++) begin
                if (seg >= 2 * SEG_COUNT / 3 && i == SEG_BEATS / 3) begin
                    push_item(ITEM_HOLD, '0, '0, '0, HOLD_LEN, 0);
                end
                if (seg >= 2 * SEG_COUNT / 3 && i == 2 * SEG_BEATS / 3) begin
                    push_item(ITEM_DRAIN, '0, '0, '0, 0, 0);
                end
                add_sample(rand_sample());
            end
        end

        // hold reset, then release
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait on the falling edge, away from the updates at the rising one
        do begin
            @(negedge i_clk);
        end while (pend.size() != 0 || i_in_valid || i_cfg_valid || in_flight > 0);
        repeat (DRAIN_TAIL) @(negedge i_clk);

        if (expected_mix.size() != 0) begin
            $display("%0t: %0d predicted audio_out beats never arrived, expected %0d, actual none",
                     $time, expected_mix.size(), expected_mix[0]);
            mismatches++;
        end

        if (mismatches == 0) begin
            $display("** hilbert_frequency_shifter: PASSED **");
        end else begin
            $display("** hilbert_frequency_shifter: FAILED **");
        end
        $finish;
    end

endmodule
